>>> src/cirs_pkg.sv
// ----------------------------------------------------------------------------
// Report scheduler package
// Shared types, codes and constants of the report scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package cirs_pkg;

  localparam int unsigned DefaultEntries = 16;

  typedef enum logic [3:0] {
    FN_RUN       = 4'd0,
    FN_SETUP     = 4'd1,
    FN_SETUP_ARG = 4'd2,
    FN_SETUP_PIN = 4'd3,
    FN_CHANGE    = 4'd4,
    FN_CHANGE_CB = 4'd5,
    FN_UPDATE    = 4'd6,
    FN_RESTART   = 4'd7,
    FN_NOW       = 4'd8,
    FN_DELETE    = 4'd9,
    FN_QUERY     = 4'd10,
    FN_ENABLE    = 4'd11,
    FN_DISABLE   = 4'd12,
    FN_ENA_ALL   = 4'd13,
    FN_DIS_ALL   = 4'd14,
    FN_UNUSED    = 4'd15
  } func_t;

  localparam logic [1:0] KIND_FIRE   = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_NONE   = 2'd2;

  localparam logic [1:0] FORM_PLAIN = 2'd0;
  localparam logic [1:0] FORM_ARG   = 2'd1;
  localparam logic [1:0] FORM_PIN   = 2'd2;

  // request as it is broadcast to every cell
  typedef struct packed {
    logic [3:0]  func;
    logic [7:0]  entry_id;
    logic [31:0] now_ms;
    logic [31:0] min_interval;
    logic [31:0] max_interval;
    logic [31:0] min_change;
    logic [31:0] value;
    logic [31:0] pin_data;
    logic [31:0] callback_tag;
    logic [31:0] arg_tag;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        ok;
    logic [5:0]  out_entry;
    logic [1:0]  call_form;
    logic [31:0] out_callback;
    logic [31:0] out_arg;
    logic [7:0]  out_pin;
    logic [7:0]  out_pin_mode;
    logic [15:0] out_config_id;
    logic [31:0] out_value;
    logic        last;
  } res_t;

  // what one cell reports back on its step
  typedef struct packed {
    logic        valid;
    logic        enabled;
    logic        fire;
    res_t        res;
  } cell_out_t;

endpackage
`default_nettype wire

>>> src/cirs_if.sv
// ----------------------------------------------------------------------------
// Report scheduler channel
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface cirs_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/cirs_cell.sv
// ----------------------------------------------------------------------------
// Report scheduler cell
// Holds one report entry and acts on the request when the sequencer steps it.
// ----------------------------------------------------------------------------
`default_nettype none
module cirs_cell #(
  parameter int unsigned IDX_W = 4,
  parameter logic [IDX_W-1:0] INDEX = '0
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire logic           alloc,
  input  wire cirs_pkg::req_t req,
  output cirs_pkg::cell_out_t co
);
  import cirs_pkg::*;

  logic        valid, enabled, updated;
  logic [31:0] last_time, lo_int, hi_int, thr, cur, prev, cb, arg, pd;
  logic [1:0]  form;

  logic        hit;
  logic [31:0] elapsed;
  logic [32:0] diff, mag;
  logic        fires;

  assign hit     = (req.entry_id[7:IDX_W] == '0 || IDX_W == 8) &&
                   req.entry_id[IDX_W-1:0] == INDEX;
  assign elapsed = req.now_ms - last_time;
  assign diff    = {cur[31], cur} - {prev[31], prev};
  assign mag     = diff[32] ? (33'd0 - diff) : diff;
  assign fires   = valid && elapsed >= lo_int &&
                   (!($signed(mag) < $signed({thr[31], thr})) || elapsed >= hi_int);

  // report fire data
  always_comb begin
    co.valid   = valid;
    co.enabled = enabled;
    co.fire    = fires && updated && enabled;
    co.res     = '0;
    co.res.kind = KIND_FIRE;
    co.res.ok  = 1'b1;
    co.res.out_entry = 6'(INDEX);
    co.res.call_form = form;
    co.res.out_callback = cb;
    co.res.out_arg = (form == FORM_ARG) ? arg : 32'd0;
    if (form == FORM_PIN) begin
      co.res.out_pin = pd[7:0];
      co.res.out_pin_mode = pd[15:8];
      co.res.out_config_id = pd[31:16];
    end
    co.res.out_value = cur;
  end

  // apply the request
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0; enabled <= 1'b0; updated <= 1'b0;
      last_time <= '0; lo_int <= '0; hi_int <= '0; thr <= '0; cur <= '0;
      prev <= '0; cb <= '0; arg <= '0; pd <= '0; form <= FORM_PLAIN;
    end else if (step) begin
      unique case (func_t'(req.func))
        FN_RUN: if (fires) begin
          last_time <= req.now_ms;
          prev <= cur;
        end
        FN_SETUP, FN_SETUP_ARG, FN_SETUP_PIN: if (alloc) begin
          valid <= 1'b1; enabled <= 1'b1; updated <= 1'b0;
          thr <= req.min_change; lo_int <= req.min_interval;
          hi_int <= req.max_interval; last_time <= req.now_ms;
          cur <= '0; prev <= '0; cb <= req.callback_tag;
          form <= req.func[1:0] - 2'd1;
          arg <= (req.func == FN_SETUP_ARG) ? req.arg_tag : 32'd0;
          pd <= (req.func == FN_SETUP_PIN) ? req.pin_data : 32'd0;
        end
        FN_CHANGE, FN_CHANGE_CB:
          if (hit && valid && req.min_interval != '0 &&
              req.max_interval >= req.min_interval) begin
            thr <= req.min_change; lo_int <= req.min_interval;
            hi_int <= req.max_interval;
            if (req.func == FN_CHANGE_CB) begin
              form <= FORM_PIN; cb <= req.callback_tag; arg <= '0;
              pd <= req.pin_data;
            end
          end
        FN_UPDATE: if (hit) begin
          cur <= req.value;
          if (!updated) begin
            prev <= req.value;
            last_time <= req.now_ms - lo_int;
          end
          updated <= 1'b1;
        end
        FN_RESTART: if (hit) begin
          updated <= 1'b0;
          last_time <= req.now_ms;
        end
        FN_NOW: if (hit) last_time <= req.now_ms - hi_int;
        FN_DELETE: if (hit && valid) begin
          valid <= 1'b0; enabled <= 1'b0; updated <= 1'b0;
          last_time <= req.now_ms; lo_int <= '0; hi_int <= '0; thr <= '0;
          cur <= '0; prev <= '0; cb <= '0; arg <= '0; pd <= '0;
          form <= FORM_PLAIN;
        end
        FN_ENABLE: if (hit) enabled <= 1'b1;
        FN_DISABLE: if (hit) enabled <= 1'b0;
        FN_ENA_ALL: if (valid) enabled <= 1'b1;
        FN_DIS_ALL: if (valid) enabled <= 1'b0;
        FN_QUERY, FN_UNUSED: ;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> src/change_interval_report_scheduler_top.sv
// A request is taken, then the sequencer steps one entry cell per cycle in
// index order, queuing each result into the output register; the step holds
// while the output register is full and the output is stalled. A send state
// then forms the closing status or "nothing fired" result where one is due,
// and the next request is accepted only once the block is back in idle. The
// per-entry scan over the row of cells sets how long a request occupies the
// block. Every function except a run gives one status result; a run gives one
// result per reporting entry, or one "nothing fired" result.
// ----------------------------------------------------------------------------
// Report scheduler top
// Table of report entries with min/max interval and reportable change.
// ----------------------------------------------------------------------------
`default_nettype none
module change_interval_report_scheduler_top #(
  parameter int unsigned ENTRIES = cirs_pkg::DefaultEntries
) (
  input wire logic clk,
  input wire logic rst,
  cirs_if.sink     in_ch,
  cirs_if.source   out_ch
);
  import cirs_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_SEND = 3'b100
  } state_t;

  state_t            state, state_next;
  req_t              req;
  logic [IDX_W-1:0]  pos;
  logic [CNT_W-1:0]  count;
  logic              any_fired, found, status_ok;
  logic [5:0]        found_idx;
  res_t              hold, hold_next;
  logic              hold_valid, hold_valid_next;
  cell_out_t         co [ENTRIES];
  logic [ENTRIES-1:0] step_vec, alloc_vec, above_vec;
  cell_out_t         cur_co;
  logic              is_run, is_setup, inr, last_pos, can_step, later_fire;

  assign cur_co   = co[pos];
  assign is_run   = req.func == FN_RUN;
  assign is_setup = req.func == FN_SETUP || req.func == FN_SETUP_ARG ||
                    req.func == FN_SETUP_PIN;
  assign inr      = req.entry_id < 8'(ENTRIES);
  assign last_pos = pos == IDX_W'(ENTRIES - 1);
  assign can_step = state == ST_SCAN && (!hold_valid || out_ch.ready);
  assign later_fire = |above_vec;

  genvar g;
  for (g = 0; g < ENTRIES; g++) begin : g_cell
    assign step_vec[g]  = can_step && pos == IDX_W'(g);
    assign alloc_vec[g] = !co[g].valid && !found && count < CNT_W'(ENTRIES) &&
                          req.min_interval != '0 &&
                          req.max_interval >= req.min_interval;
    // an entry past the current one that will also report on this run
    assign above_vec[g] = co[g].fire && IDX_W'(g) > pos;
    cirs_cell #(.IDX_W(IDX_W), .INDEX(IDX_W'(g))) u_cell (
      .clk, .rst, .step(step_vec[g]), .alloc(alloc_vec[g]), .req, .co(co[g])
    );
  end

  assign in_ch.ready  = state == ST_IDLE;
  assign out_ch.valid = hold_valid;
  assign out_ch.data  = hold;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_ch.valid) state_next = ST_SCAN;
      ST_SCAN: if (can_step && last_pos) state_next = ST_SEND;
      ST_SEND: if (!hold_valid || out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // form the next content of the output register
  always_comb begin
    hold_next = hold;
    hold_valid_next = hold_valid && !out_ch.ready;
    unique case (state)
      ST_SCAN: if (can_step && is_run && cur_co.fire) begin
        hold_next = cur_co.res;
        hold_next.last = !later_fire;
        hold_valid_next = 1'b1;
      end
      ST_SEND: if ((!hold_valid || out_ch.ready) && !(is_run && any_fired)) begin
        hold_next = '0;
        hold_next.last = 1'b1;
        hold_valid_next = 1'b1;
        if (is_run) begin
          hold_next.kind = KIND_NONE;
          hold_next.ok = 1'b1;
        end else begin
          hold_next.kind = KIND_STATUS;
          if (is_setup) begin
            hold_next.ok = found;
            hold_next.out_entry = found_idx;
          end else if (req.func == FN_ENA_ALL || req.func == FN_DIS_ALL) begin
            hold_next.ok = 1'b1;
          end else begin
            hold_next.ok = status_ok;
          end
        end
      end
      default: ;
    endcase
  end

  // sequence the scan and drive the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; hold_valid <= 1'b0; count <= '0; pos <= '0;
    end else begin
      state <= state_next;
      hold <= hold_next;
      hold_valid <= hold_valid_next;
      unique case (state)
        ST_IDLE: if (in_ch.valid) begin
          req <= in_ch.data; pos <= '0; any_fired <= 1'b0; found <= 1'b0;
          found_idx <= '0; status_ok <= 1'b0;
        end
        ST_SCAN: if (can_step) begin
          pos <= last_pos ? '0 : pos + 1'b1;
          if (is_run && cur_co.fire) any_fired <= 1'b1;
          if (alloc_vec[pos] && is_setup) begin
            found <= 1'b1; found_idx <= 6'(pos); count <= count + 1'b1;
          end
          if (req.entry_id[IDX_W-1:0] == pos && inr) begin
            unique case (func_t'(req.func))
              FN_CHANGE, FN_CHANGE_CB: status_ok <= cur_co.valid &&
                req.min_interval != '0 && req.max_interval >= req.min_interval;
              FN_DELETE: begin
                status_ok <= cur_co.valid && count != '0;
                if (cur_co.valid && count != '0) count <= count - 1'b1;
              end
              FN_QUERY: status_ok <= cur_co.enabled;
              FN_UPDATE, FN_RESTART, FN_NOW, FN_ENABLE, FN_DISABLE:
                status_ok <= 1'b1;
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES)) else $error("entry count overflow");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> state == ST_SCAN) else $error("no scan");
  a_onestep: assert property (@(posedge clk) disable iff (rst)
    $onehot0(step_vec)) else $error("two cells stepped");
  a_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> step_vec == '0) else $error("step while idle");
`endif
endmodule
`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// Report scheduler testbench
// Drives requests into the report scheduler with random gaps on both sides,
// predicts every result from a behavioral copy of the entry table, and
// compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import cirs_pkg::*;

  localparam int unsigned NUM_ENTRIES = 16;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cirs_if #(.T(req_t)) req_ch (.clk(clk));
  cirs_if #(.T(res_t)) res_ch (.clk(clk));

  change_interval_report_scheduler_top #(.ENTRIES(NUM_ENTRIES)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (req_ch.sink),
    .out_ch (res_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted entry table
  logic        tbl_valid   [NUM_ENTRIES];
  logic        tbl_enabled [NUM_ENTRIES];
  logic        tbl_updated [NUM_ENTRIES];
  logic [31:0] tbl_time    [NUM_ENTRIES];
  logic [31:0] tbl_lo      [NUM_ENTRIES];
  logic [31:0] tbl_hi      [NUM_ENTRIES];
  logic [31:0] tbl_thr     [NUM_ENTRIES];
  logic [31:0] tbl_cur     [NUM_ENTRIES];
  logic [31:0] tbl_prev    [NUM_ENTRIES];
  logic [1:0]  tbl_form    [NUM_ENTRIES];
  logic [31:0] tbl_cb      [NUM_ENTRIES];
  logic [31:0] tbl_arg     [NUM_ENTRIES];
  logic [31:0] tbl_pin     [NUM_ENTRIES];
  int unsigned tbl_count;

  res_t        pending_results[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic void clear_slot(input int i);
    tbl_valid[i] = 0; tbl_enabled[i] = 0; tbl_updated[i] = 0;
    tbl_time[i] = 0; tbl_lo[i] = 0; tbl_hi[i] = 0; tbl_thr[i] = 0;
    tbl_cur[i] = 0; tbl_prev[i] = 0; tbl_form[i] = FORM_PLAIN;
    tbl_cb[i] = 0; tbl_arg[i] = 0; tbl_pin[i] = 0;
  endfunction

  function automatic res_t status(input logic ok, input logic [5:0] ent);
    res_t r;
    r = '0;
    r.kind = KIND_STATUS;
    r.ok = ok;
    r.out_entry = ent;
    r.last = 1'b1;
    return r;
  endfunction

  // advance the table by one request and queue its results
  function automatic void predict_schedule(input req_t q);
    res_t        r;
    logic [31:0] el;
    longint      d;
    int          f;
    int          n;
    logic        inr;
    logic        ok;
    inr = q.entry_id < NUM_ENTRIES;
    n = 0;
    f = -1;
    case (func_t'(q.func))
      FN_RUN: begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (!tbl_valid[i]) continue;
          el = q.now_ms - tbl_time[i];
          if (el < tbl_lo[i]) continue;
          d = longint'($signed(tbl_cur[i])) - longint'($signed(tbl_prev[i]));
          if (d < 0) d = -d;
          if (d < longint'($signed(tbl_thr[i])) && el < tbl_hi[i]) continue;
          tbl_time[i] = q.now_ms;
          tbl_prev[i] = tbl_cur[i];
          if (!tbl_updated[i] || !tbl_enabled[i]) continue;
          r = '0;
          r.kind = KIND_FIRE;
          r.ok = 1'b1;
          r.out_entry = 6'(i);
          r.call_form = tbl_form[i];
          r.out_callback = tbl_cb[i];
          if (tbl_form[i] == FORM_ARG) r.out_arg = tbl_arg[i];
          if (tbl_form[i] == FORM_PIN) begin
            r.out_pin = tbl_pin[i][7:0];
            r.out_pin_mode = tbl_pin[i][15:8];
            r.out_config_id = tbl_pin[i][31:16];
          end
          r.out_value = tbl_cur[i];
          pending_results.push_back(r);
          n++;
        end
        if (n == 0) begin
          r = '0;
          r.kind = KIND_NONE;
          r.ok = 1'b1;
          r.last = 1'b1;
          pending_results.push_back(r);
        end else begin
          pending_results[$].last = 1'b1;
        end
      end
      FN_SETUP, FN_SETUP_ARG, FN_SETUP_PIN: begin
        if (tbl_count < NUM_ENTRIES)
          for (int i = 0; i < NUM_ENTRIES; i++)
            if (!tbl_valid[i]) begin f = i; break; end
        if (f < 0 || q.min_interval == 0 || q.max_interval < q.min_interval) begin
          pending_results.push_back(status(1'b0, 6'd0));
        end else begin
          clear_slot(f);
          tbl_valid[f] = 1; tbl_enabled[f] = 1;
          tbl_thr[f] = q.min_change; tbl_lo[f] = q.min_interval;
          tbl_hi[f] = q.max_interval; tbl_time[f] = q.now_ms;
          tbl_cb[f] = q.callback_tag;
          tbl_form[f] = 2'(q.func - 4'd1);
          if (q.func == FN_SETUP_ARG) tbl_arg[f] = q.arg_tag;
          if (q.func == FN_SETUP_PIN) tbl_pin[f] = q.pin_data;
          tbl_count++;
          pending_results.push_back(status(1'b1, 6'(f)));
        end
      end
      FN_CHANGE, FN_CHANGE_CB: begin
        if (!inr || q.min_interval == 0 || q.max_interval < q.min_interval ||
            !tbl_valid[q.entry_id[3:0]]) begin
          pending_results.push_back(status(1'b0, 6'd0));
        end else begin
          f = q.entry_id;
          tbl_thr[f] = q.min_change; tbl_lo[f] = q.min_interval;
          tbl_hi[f] = q.max_interval;
          if (q.func == FN_CHANGE_CB) begin
            tbl_form[f] = FORM_PIN; tbl_cb[f] = q.callback_tag;
            tbl_arg[f] = 0; tbl_pin[f] = q.pin_data;
          end
          pending_results.push_back(status(1'b1, 6'd0));
        end
      end
      FN_UPDATE: begin
        if (inr) begin
          f = q.entry_id;
          tbl_cur[f] = q.value;
          if (!tbl_updated[f]) begin
            tbl_prev[f] = q.value;
            tbl_time[f] = q.now_ms - tbl_lo[f];
          end
          tbl_updated[f] = 1;
        end
        pending_results.push_back(status(inr, 6'd0));
      end
      FN_RESTART: begin
        if (inr) begin
          tbl_updated[q.entry_id] = 0;
          tbl_time[q.entry_id] = q.now_ms;
        end
        pending_results.push_back(status(inr, 6'd0));
      end
      FN_NOW: begin
        if (inr) tbl_time[q.entry_id] = q.now_ms - tbl_hi[q.entry_id];
        pending_results.push_back(status(inr, 6'd0));
      end
      FN_DELETE: begin
        ok = inr && tbl_count != 0 && tbl_valid[q.entry_id[3:0]];
        if (ok) begin
          clear_slot(q.entry_id);
          tbl_time[q.entry_id] = q.now_ms;
          tbl_count--;
        end
        pending_results.push_back(status(ok, 6'd0));
      end
      FN_QUERY:
        pending_results.push_back(status(inr && tbl_enabled[q.entry_id[3:0]], 6'd0));
      FN_ENABLE, FN_DISABLE: begin
        if (inr) tbl_enabled[q.entry_id] = (q.func == FN_ENABLE);
        pending_results.push_back(status(inr, 6'd0));
      end
      FN_ENA_ALL, FN_DIS_ALL: begin
        for (int i = 0; i < NUM_ENTRIES; i++)
          if (tbl_valid[i]) tbl_enabled[i] = (q.func == FN_ENA_ALL);
        pending_results.push_back(status(1'b1, 6'd0));
      end
      default: pending_results.push_back(status(1'b0, 6'd0));
    endcase
  endfunction

  // gap length: mostly zero or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic req_t make_req(input func_t fn, input logic [7:0] id,
                                    input logic [31:0] now, input logic [31:0] mn,
                                    input logic [31:0] mx, input logic [31:0] thr,
                                    input logic [31:0] val);
    req_t q;
    q.func = fn; q.entry_id = id; q.now_ms = now;
    q.min_interval = mn; q.max_interval = mx; q.min_change = thr;
    q.value = val; q.pin_data = $urandom; q.callback_tag = $urandom;
    q.arg_tag = $urandom;
    return q;
  endfunction

  // sending side: idle for a gap, then hold the request until accepted
  task automatic send_request(input req_t q);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= q;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predict_schedule(q);
    @(negedge clk);
  endtask

  // receiving side: random stalls, compare at the accepting edge
  logic stall_mode;
  int unsigned stall_left;
  initial begin
    res_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if (stall_mode && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    cycles++;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = res_ch.data;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", got));
      end else begin
        want = pending_results.pop_front();
        if (got.kind != want.kind)
          report_mismatch($sformatf("kind %0d want %0d", got.kind, want.kind));
        if (got.ok != want.ok)
          report_mismatch($sformatf("ok %0d want %0d", got.ok, want.ok));
        if (got.out_entry != want.out_entry)
          report_mismatch($sformatf("entry %0d want %0d", got.out_entry, want.out_entry));
        if (got.call_form != want.call_form)
          report_mismatch($sformatf("form %0d want %0d", got.call_form, want.call_form));
        if (got.out_callback != want.out_callback)
          report_mismatch($sformatf("callback %h want %h", got.out_callback,
                                    want.out_callback));
        if (got.out_arg != want.out_arg)
          report_mismatch($sformatf("arg %h want %h", got.out_arg, want.out_arg));
        if (got.out_pin != want.out_pin)
          report_mismatch($sformatf("pin %h want %h", got.out_pin, want.out_pin));
        if (got.out_pin_mode != want.out_pin_mode)
          report_mismatch($sformatf("pin mode %h want %h", got.out_pin_mode,
                                    want.out_pin_mode));
        if (got.out_config_id != want.out_config_id)
          report_mismatch($sformatf("config %h want %h", got.out_config_id,
                                    want.out_config_id));
        if (got.out_value != want.out_value)
          report_mismatch($sformatf("value %h want %h", got.out_value, want.out_value));
        if (got.last != want.last)
          report_mismatch($sformatf("last %0d want %0d", got.last, want.last));
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // directed rows: function, id, time, min, max, threshold, value, and where
  // the answer is obvious, a typed kind and ok
  typedef struct {
    func_t       fn;
    logic [7:0]  id;
    logic [31:0] now;
    logic [31:0] mn;
    logic [31:0] mx;
    logic [31:0] thr;
    logic [31:0] val;
    logic        chk;
    logic [1:0]  kind;
    logic        ok;
  } row_t;

  row_t directed[] = '{
    '{FN_RUN,       8'd0,   32'd0,  32'd0, 32'd0, 32'd0, 32'd0, 1'b1, KIND_NONE, 1'b1},
    '{FN_QUERY,     8'd0,   32'd0,  32'd0, 32'd0, 32'd0, 32'd0, 1'b1, KIND_STATUS, 1'b0},
    '{FN_SETUP,     8'd0,   32'd0,  32'd0, 32'd5, 32'd0, 32'd0, 1'b1, KIND_STATUS, 1'b0},
    '{FN_SETUP,     8'd0,   32'd0,  32'd9, 32'd5, 32'd0, 32'd0, 1'b1, KIND_STATUS, 1'b0},
    '{FN_SETUP,     8'd0,   32'd100, 32'd10, 32'd50, 32'h0001_0000, 32'd0,
      1'b0, KIND_STATUS, 1'b0},
    '{FN_SETUP_ARG, 8'd0,   32'hFFFF_FFF0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0,
      1'b0, KIND_STATUS, 1'b0},
    '{FN_SETUP_PIN, 8'd0,   32'd100, 32'd5, 32'd5, 32'h8000_0000, 32'd0,
      1'b0, KIND_STATUS, 1'b0},
    '{FN_UPDATE,    8'd0,   32'd200, 32'd0, 32'd0, 32'd0, 32'h8000_0000,
      1'b0, KIND_STATUS, 1'b0},
    '{FN_UPDATE,    8'd0,   32'd205, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF,
      1'b0, KIND_STATUS, 1'b0},
    '{FN_UPDATE,    8'd1,   32'd5,  32'd0, 32'd0, 32'd0, 32'hFFFF_0000,
      1'b0, KIND_STATUS, 1'b0},
    '{FN_UPDATE,    8'd2,   32'd5,  32'd0, 32'd0, 32'd0, 32'd3, 1'b0, KIND_STATUS, 1'b0},
    '{FN_RUN,       8'd0,   32'd210, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, KIND_FIRE, 1'b0},
    '{FN_NOW,       8'd1,   32'd300, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, KIND_STATUS, 1'b0},
    '{FN_RUN,       8'd0,   32'd300, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, KIND_FIRE, 1'b0},
    '{FN_CHANGE,    8'd255, 32'd0,  32'd1, 32'd2, 32'd0, 32'd0, 1'b1, KIND_STATUS, 1'b0},
    '{FN_CHANGE_CB, 8'd2,   32'd0,  32'd1, 32'd2, 32'd0, 32'd0, 1'b0, KIND_STATUS, 1'b0},
    '{FN_CHANGE,    8'd9,   32'd0,  32'd1, 32'd2, 32'd0, 32'd0, 1'b0, KIND_STATUS, 1'b0},
    '{FN_DISABLE,   8'd0,   32'd0,  32'd0, 32'd0, 32'd0, 32'd0, 1'b1, KIND_STATUS, 1'b1},
    '{FN_DIS_ALL,   8'd0,   32'd0,  32'd0, 32'd0, 32'd0, 32'd0, 1'b1, KIND_STATUS, 1'b1},
    '{FN_ENA_ALL,   8'd0,   32'd0,  32'd0, 32'd0, 32'd0, 32'd0, 1'b1, KIND_STATUS, 1'b1},
    '{FN_ENABLE,    8'd16,  32'd0,  32'd0, 32'd0, 32'd0, 32'd0, 1'b1, KIND_STATUS, 1'b0},
    '{FN_RESTART,   8'd2,   32'd400, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, KIND_STATUS, 1'b1},
    '{FN_DELETE,    8'd1,   32'd400, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, KIND_STATUS, 1'b0},
    '{FN_DELETE,    8'd1,   32'd400, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, KIND_STATUS, 1'b0},
    '{FN_UNUSED,    8'd0,   32'd0,  32'd0, 32'd0, 32'd0, 32'd0, 1'b1, KIND_STATUS, 1'b0}
  };

  initial begin
    req_t        q;
    logic [31:0] clock_ms;
    int unsigned p;
    int unsigned wait_cycles;
    logic [7:0]  id;
    logic [31:0] mn;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    stall_mode = 1'b0;
    for (int i = 0; i < NUM_ENTRIES; i++) clear_slot(i);
    tbl_count = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, with stalls only in its second half
    foreach (directed[k]) begin
      if (k == 12) stall_mode = 1'b1;
      send_request(make_req(directed[k].fn, directed[k].id, directed[k].now,
                            directed[k].mn, directed[k].mx, directed[k].thr,
                            directed[k].val));
      if (directed[k].chk && (pending_results[$].kind != directed[k].kind ||
                              pending_results[$].ok != directed[k].ok))
        report_mismatch($sformatf("row %0d: kind %0d ok %0d typed %0d %0d", k,
                                  pending_results[$].kind, pending_results[$].ok,
                                  directed[k].kind, directed[k].ok));
    end

    // random part: mostly well-formed traffic on a slowly advancing clock
    clock_ms = $urandom;
    for (int n = 0; n < 300; n++) begin
      if (n % 60 == 30) stall_mode = 1'b0;
      if (n % 60 == 45) stall_mode = 1'b1;
      clock_ms += $urandom_range(0, 40);
      id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
      mn = $urandom_range(0, 8) == 0 ? 32'd0 : $urandom_range(1, 60);
      p = $urandom_range(0, 99);
      if (p < 30)
        q = make_req(FN_RUN, id, clock_ms, 0, 0, 0, 0);
      else if (p < 45)
        q = make_req(func_t'($urandom_range(FN_SETUP, FN_SETUP_PIN)), id, clock_ms,
                     mn, mn + $urandom_range(0, 100) - ($urandom_range(0, 9) == 0),
                     $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 32'h3_0000),
                     $urandom);
      else if (p < 70)
        q = make_req(FN_UPDATE, id, clock_ms, 0, 0, 0,
                     $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 32'h4_0000));
      else if (p < 80)
        q = make_req(func_t'($urandom_range(FN_CHANGE, FN_CHANGE_CB)), id, clock_ms,
                     mn, mn + $urandom_range(0, 100) - ($urandom_range(0, 9) == 0),
                     $urandom_range(0, 32'h3_0000), 0);
      else
        q = make_req(func_t'($urandom_range(FN_RESTART, FN_UNUSED)), id, clock_ms,
                     $urandom, $urandom, $urandom, $urandom);
      // occasional full-range noise on the payload bits
      if ($urandom_range(0, 19) == 0) begin
        q.min_interval = $urandom; q.max_interval = $urandom;
        q.min_change = $urandom; q.value = $urandom; q.now_ms = $urandom;
      end
      send_request(q);
    end
    req_ch.valid <= 1'b0;

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (2 * NUM_ENTRIES + 20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> sim.f
src/cirs_pkg.sv
src/cirs_if.sv
src/cirs_cell.sv
src/change_interval_report_scheduler_top.sv
test/tb.sv
